// ===== rtl/scpc_pkg.sv =====
// package with widths, constants and payload types for the sphere and cone point classifier
package scpc_pkg;

    localparam int COORD_W     = 16;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int RADIUS_W    = 15;
    localparam int RADIUS_SQ_W = 2 * RADIUS_W;

    localparam int SQ_D_W  = 2 * DIFF_W;
    localparam int SQ_A_W  = 2 * COORD_W;
    localparam int PAD_W   = COORD_W + DIFF_W;
    localparam int D2_W    = 2 * DIFF_W;
    localparam int A2_W    = 2 * COORD_W;
    localparam int DOT_W   = 2 * COORD_W + 2;
    localparam int ADOT_W  = DOT_W - 1;

    localparam int D2_LO_W   = D2_W / 2;
    localparam int D2_HI_W   = D2_W - D2_LO_W;
    localparam int ADOT_LO_W = (ADOT_W + 1) / 2;
    localparam int ADOT_HI_W = ADOT_W - ADOT_LO_W;

    localparam int PA_LO_W = A2_W + D2_LO_W;
    localparam int PA_HI_W = A2_W + D2_HI_W;
    localparam int PQ_LO_W = ADOT_W + ADOT_LO_W;
    localparam int PQ_HI_W = ADOT_W + ADOT_HI_W;

    localparam int WIDE_W    = A2_W + D2_W;
    localparam int WIDE_LO_W = WIDE_W / 2;
    localparam int WIDE_HI_W = WIDE_W - WIDE_LO_W;

    localparam int K_W      = 18;
    localparam int PROD_W   = WIDE_W + K_W;
    localparam int DEN_SHIFT = 4;
    localparam int CMP_W    = PROD_W + DEN_SHIFT;

    // cos^2 thresholds as num / den
    localparam logic [K_W-1:0] K_NUM_70 = K_W'(159201);
    localparam logic [K_W-1:0] K_NUM_48 = K_W'(9801);
    localparam logic [K_W-1:0] K_NUM_30 = K_W'(154449);
    localparam logic [K_W-1:0] K_DEN    = K_W'(10000);

    // squared band distances in (1/16 cm)^2
    localparam logic [D2_W-1:0] D2_LIM_70 = D2_W'(1120 * 1120);
    localparam logic [D2_W-1:0] D2_LIM_48 = D2_W'(768 * 768);
    localparam logic [D2_W-1:0] D2_LIM_30 = D2_W'(480 * 480);

    localparam int PIPE_DEPTH = 8;
    localparam int LATENCY    = PIPE_DEPTH + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] axis_x;
        logic signed [COORD_W-1:0] axis_y;
        logic signed [COORD_W-1:0] axis_z;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_item;

    typedef struct packed {
        logic accepted;
        logic inside_sphere;
        logic backward_band;
    } t_result;

    typedef struct packed {
        logic in_sphere;
        logic near_70;
        logic near_48;
        logic near_30;
        logic dot_neg;
        logic dot_pos;
    } t_flags;

endpackage

// ===== rtl/sphere_cone_point_classifier.sv =====
// sphere and cone point classifier, fully pipelined
// a result strobes once its transfer on start has passed the stage registers and the result register
// throughput: one item per cycle, busy is always low; the multiplier stages set the depth
// the receiver cannot stall, so every stage advances on every clock
// reset clears the valid bits, the output strobe and the squared radius (radius 0)
module sphere_cone_point_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  scpc_pkg::t_item               i_item,
    input  logic                          i_cfg_we,
    input  logic [scpc_pkg::RADIUS_W-1:0] i_cfg_data,
    output logic                          o_strobe,
    output scpc_pkg::t_result             o_result
);

    logic [scpc_pkg::RADIUS_SQ_W-1:0] r_radius_sq;
    logic [scpc_pkg::PIPE_DEPTH-1:0]  r_vld;
    logic                             r_strobe;
    scpc_pkg::t_result                r_result;

    // stage 1
    logic signed [scpc_pkg::DIFF_W-1:0]  r_s1_dx, r_s1_dy, r_s1_dz;
    logic signed [scpc_pkg::COORD_W-1:0] r_s1_ax, r_s1_ay, r_s1_az;
    // stage 2
    logic signed [scpc_pkg::SQ_D_W-1:0] r_s2_dxx, r_s2_dyy, r_s2_dzz;
    logic signed [scpc_pkg::SQ_A_W-1:0] r_s2_axx, r_s2_ayy, r_s2_azz;
    logic signed [scpc_pkg::PAD_W-1:0]  r_s2_px, r_s2_py, r_s2_pz;
    // stage 3
    logic [scpc_pkg::D2_W-1:0]         r_s3_d2;
    logic [scpc_pkg::A2_W-1:0]         r_s3_a2;
    logic signed [scpc_pkg::DOT_W-1:0] r_s3_dot;
    // stage 4
    logic [scpc_pkg::D2_W-1:0]   r_s4_d2;
    logic [scpc_pkg::A2_W-1:0]   r_s4_a2;
    logic [scpc_pkg::ADOT_W-1:0] r_s4_adot;
    logic                        r_s4_dot_neg, r_s4_dot_pos;
    // stage 5
    logic [scpc_pkg::PA_LO_W-1:0] r_s5_pa_lo;
    logic [scpc_pkg::PA_HI_W-1:0] r_s5_pa_hi;
    logic [scpc_pkg::PQ_LO_W-1:0] r_s5_pq_lo;
    logic [scpc_pkg::PQ_HI_W-1:0] r_s5_pq_hi;
    scpc_pkg::t_flags             r_s5_flags;
    // stage 6
    logic [scpc_pkg::WIDE_W-1:0] r_s6_a2d2, r_s6_dot2;
    scpc_pkg::t_flags            r_s6_flags;
    // stage 7
    logic [scpc_pkg::WIDE_LO_W+scpc_pkg::K_W-1:0] r_s7_m70_lo, r_s7_m48_lo, r_s7_m30_lo;
    logic [scpc_pkg::WIDE_LO_W+scpc_pkg::K_W-1:0] r_s7_md_lo;
    logic [scpc_pkg::WIDE_HI_W+scpc_pkg::K_W-1:0] r_s7_m70_hi, r_s7_m48_hi, r_s7_m30_hi;
    logic [scpc_pkg::WIDE_HI_W+scpc_pkg::K_W-1:0] r_s7_md_hi;
    logic                                         r_s7_cone_out;
    scpc_pkg::t_flags                             r_s7_flags;
    // stage 8
    logic [scpc_pkg::PROD_W-1:0] r_s8_m70, r_s8_m48, r_s8_m30, r_s8_md;
    logic                        r_s8_cone_out;
    scpc_pkg::t_flags            r_s8_flags;

    logic [scpc_pkg::CMP_W-1:0] n_den_x1, n_den_x16;
    logic                       n_band_70, n_band_48, n_band_30, n_band;

    assign busy = 1'b0;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_sq <= '0;
            r_vld       <= '0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radius_sq <= scpc_pkg::RADIUS_SQ_W'(i_cfg_data * i_cfg_data);
            end
            r_vld    <= {r_vld[scpc_pkg::PIPE_DEPTH-2:0], start & ~busy};
            r_strobe <= r_vld[scpc_pkg::PIPE_DEPTH-1];
        end
    end

    // stages 1 to 4: displacement, products, sums, magnitude of the dot product
    always_ff @(posedge i_clk) begin
        r_s1_dx <= {i_item.point_x[scpc_pkg::COORD_W-1], i_item.point_x}
                 - {i_item.origin_x[scpc_pkg::COORD_W-1], i_item.origin_x};
        r_s1_dy <= {i_item.point_y[scpc_pkg::COORD_W-1], i_item.point_y}
                 - {i_item.origin_y[scpc_pkg::COORD_W-1], i_item.origin_y};
        r_s1_dz <= {i_item.point_z[scpc_pkg::COORD_W-1], i_item.point_z}
                 - {i_item.origin_z[scpc_pkg::COORD_W-1], i_item.origin_z};
        r_s1_ax <= i_item.axis_x;
        r_s1_ay <= i_item.axis_y;
        r_s1_az <= i_item.axis_z;

        r_s2_dxx <= r_s1_dx * r_s1_dx;
        r_s2_dyy <= r_s1_dy * r_s1_dy;
        r_s2_dzz <= r_s1_dz * r_s1_dz;
        r_s2_axx <= r_s1_ax * r_s1_ax;
        r_s2_ayy <= r_s1_ay * r_s1_ay;
        r_s2_azz <= r_s1_az * r_s1_az;
        r_s2_px  <= r_s1_ax * r_s1_dx;
        r_s2_py  <= r_s1_ay * r_s1_dy;
        r_s2_pz  <= r_s1_az * r_s1_dz;

        r_s3_d2  <= scpc_pkg::D2_W'(r_s2_dxx + r_s2_dyy + r_s2_dzz);
        r_s3_a2  <= scpc_pkg::A2_W'(r_s2_axx + r_s2_ayy + r_s2_azz);
        r_s3_dot <= scpc_pkg::DOT_W'(r_s2_px) + scpc_pkg::DOT_W'(r_s2_py)
                  + scpc_pkg::DOT_W'(r_s2_pz);

        r_s4_d2      <= r_s3_d2;
        r_s4_a2      <= r_s3_a2;
        r_s4_dot_neg <= r_s3_dot[scpc_pkg::DOT_W-1];
        r_s4_dot_pos <= ~r_s3_dot[scpc_pkg::DOT_W-1] && (r_s3_dot != '0);
        r_s4_adot    <= r_s3_dot[scpc_pkg::DOT_W-1]
                      ? scpc_pkg::ADOT_W'(-r_s3_dot) : scpc_pkg::ADOT_W'(r_s3_dot);
    end

    // stages 5 and 6: |A|^2 |D|^2 and (A.D)^2 as split products, sphere and distance band flags
    always_ff @(posedge i_clk) begin
        r_s5_pa_lo <= r_s4_a2 * r_s4_d2[scpc_pkg::D2_LO_W-1:0];
        r_s5_pa_hi <= r_s4_a2 * r_s4_d2[scpc_pkg::D2_W-1:scpc_pkg::D2_LO_W];
        r_s5_pq_lo <= r_s4_adot * r_s4_adot[scpc_pkg::ADOT_LO_W-1:0];
        r_s5_pq_hi <= r_s4_adot * r_s4_adot[scpc_pkg::ADOT_W-1:scpc_pkg::ADOT_LO_W];
        r_s5_flags.in_sphere <= ({{scpc_pkg::RADIUS_SQ_W{1'b0}}, r_s4_d2}
                              <= {{scpc_pkg::D2_W{1'b0}}, r_radius_sq});
        r_s5_flags.near_70 <= r_s4_d2 < scpc_pkg::D2_LIM_70;
        r_s5_flags.near_48 <= r_s4_d2 < scpc_pkg::D2_LIM_48;
        r_s5_flags.near_30 <= r_s4_d2 < scpc_pkg::D2_LIM_30;
        r_s5_flags.dot_neg <= r_s4_dot_neg;
        r_s5_flags.dot_pos <= r_s4_dot_pos;

        r_s6_a2d2  <= (scpc_pkg::WIDE_W'(r_s5_pa_hi) << scpc_pkg::D2_LO_W)
                    + scpc_pkg::WIDE_W'(r_s5_pa_lo);
        r_s6_dot2  <= (scpc_pkg::WIDE_W'(r_s5_pq_hi) << scpc_pkg::ADOT_LO_W)
                    + scpc_pkg::WIDE_W'(r_s5_pq_lo);
        r_s6_flags <= r_s5_flags;
    end

    // stages 7 and 8: scaling by the cosine constants, cone test
    always_ff @(posedge i_clk) begin
        r_s7_m70_lo <= r_s6_a2d2[scpc_pkg::WIDE_LO_W-1:0] * scpc_pkg::K_NUM_70;
        r_s7_m70_hi <= r_s6_a2d2[scpc_pkg::WIDE_W-1:scpc_pkg::WIDE_LO_W] * scpc_pkg::K_NUM_70;
        r_s7_m48_lo <= r_s6_a2d2[scpc_pkg::WIDE_LO_W-1:0] * scpc_pkg::K_NUM_48;
        r_s7_m48_hi <= r_s6_a2d2[scpc_pkg::WIDE_W-1:scpc_pkg::WIDE_LO_W] * scpc_pkg::K_NUM_48;
        r_s7_m30_lo <= r_s6_a2d2[scpc_pkg::WIDE_LO_W-1:0] * scpc_pkg::K_NUM_30;
        r_s7_m30_hi <= r_s6_a2d2[scpc_pkg::WIDE_W-1:scpc_pkg::WIDE_LO_W] * scpc_pkg::K_NUM_30;
        r_s7_md_lo  <= r_s6_dot2[scpc_pkg::WIDE_LO_W-1:0] * scpc_pkg::K_DEN;
        r_s7_md_hi  <= r_s6_dot2[scpc_pkg::WIDE_W-1:scpc_pkg::WIDE_LO_W] * scpc_pkg::K_DEN;
        // outside the cone when A.D <= 0 or 2 (A.D)^2 < |A|^2 |D|^2
        r_s7_cone_out <= ~r_s6_flags.dot_pos || ({r_s6_dot2, 1'b0} < {1'b0, r_s6_a2d2});
        r_s7_flags    <= r_s6_flags;

        r_s8_m70 <= (scpc_pkg::PROD_W'(r_s7_m70_hi) << scpc_pkg::WIDE_LO_W)
                  + scpc_pkg::PROD_W'(r_s7_m70_lo);
        r_s8_m48 <= (scpc_pkg::PROD_W'(r_s7_m48_hi) << scpc_pkg::WIDE_LO_W)
                  + scpc_pkg::PROD_W'(r_s7_m48_lo);
        r_s8_m30 <= (scpc_pkg::PROD_W'(r_s7_m30_hi) << scpc_pkg::WIDE_LO_W)
                  + scpc_pkg::PROD_W'(r_s7_m30_lo);
        r_s8_md  <= (scpc_pkg::PROD_W'(r_s7_md_hi) << scpc_pkg::WIDE_LO_W)
                  + scpc_pkg::PROD_W'(r_s7_md_lo);
        r_s8_cone_out <= r_s7_cone_out;
        r_s8_flags    <= r_s7_flags;
    end

    // final compares
    always_comb begin
        n_den_x1  = {{scpc_pkg::DEN_SHIFT{1'b0}}, r_s8_md};
        n_den_x16 = {r_s8_md, {scpc_pkg::DEN_SHIFT{1'b0}}};
        n_band_70 = r_s8_flags.near_70 && r_s8_flags.dot_neg
                 && ({{scpc_pkg::DEN_SHIFT{1'b0}}, r_s8_m70} < n_den_x16);
        n_band_48 = r_s8_flags.near_48 && r_s8_flags.dot_neg
                 && ({{scpc_pkg::DEN_SHIFT{1'b0}}, r_s8_m48} < n_den_x1);
        n_band_30 = r_s8_flags.near_30 && r_s8_flags.dot_neg
                 && ({{scpc_pkg::DEN_SHIFT{1'b0}}, r_s8_m30} < n_den_x16);
        n_band    = n_band_70 || n_band_48 || n_band_30;
    end

    always_ff @(posedge i_clk) begin
        r_result.accepted      <= r_s8_flags.in_sphere && ~n_band && r_s8_cone_out;
        r_result.inside_sphere <= r_s8_flags.in_sphere;
        r_result.backward_band <= n_band;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_accept_implies_tests: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.accepted) |-> (o_result.inside_sphere && !o_result.backward_band))
        else $error("accepted result outside sphere or in backward band");

    a_strobe_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, scpc_pkg::LATENCY))
        else $error("result strobe without a matching transfer");

    a_bands_nested: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[scpc_pkg::PIPE_DEPTH-1] && r_s8_flags.near_30)
            |-> (r_s8_flags.near_48 && r_s8_flags.near_70))
        else $error("distance bands not nested");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the sphere and cone point classifier
`timescale 1ns / 1ps

module tb;

    localparam longint BAND70_D2  = 1120 * 1120;
    localparam longint BAND48_D2  = 768 * 768;
    localparam longint BAND30_D2  = 480 * 480;
    localparam longint COS70_NUM  = 159201;
    localparam longint COS70_DEN  = 160000;
    localparam longint COS48_NUM  = 9801;
    localparam longint COS48_DEN  = 10000;
    localparam longint COS30_NUM  = 154449;
    localparam longint COS30_DEN  = 160000;
    localparam int     RADIUS_MAX = (1 << scpc_pkg::RADIUS_W) - 1;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    scpc_pkg::t_item               i_item = '0;
    logic                          i_cfg_we = 1'b0;
    logic [scpc_pkg::RADIUS_W-1:0] i_cfg_data = '0;
    logic                          o_strobe;
    scpc_pkg::t_result             o_result;

    logic [scpc_pkg::RADIUS_W-1:0] radius_model = '0;
    scpc_pkg::t_result             expected_q[$];
    scpc_pkg::t_result             want;
    int                            mismatch_count = 0;

    sphere_cone_point_classifier u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("sphere_cone_point_classifier test failed");
        $finish;
    end

    function automatic logic below_neg_cos(longint dot, logic [127:0] dot_sq,
                                           logic [127:0] ad_sq, longint num, longint den);
        if (dot >= 0) return 1'b0;
        return (ad_sq * 128'(num)) < (dot_sq * 128'(den));
    endfunction

    function automatic scpc_pkg::t_result classify_point(scpc_pkg::t_item it,
                                                         logic [scpc_pkg::RADIUS_W-1:0] radius);
        longint            dx, dy, dz, ax, ay, az, d2, a2, dot, adot, r2;
        logic [127:0]      dot_sq, ad_sq;
        logic              in_sphere, band, outside_cone;
        scpc_pkg::t_result res;
        dx = longint'($signed(it.point_x)) - longint'($signed(it.origin_x));
        dy = longint'($signed(it.point_y)) - longint'($signed(it.origin_y));
        dz = longint'($signed(it.point_z)) - longint'($signed(it.origin_z));
        ax = longint'($signed(it.axis_x));
        ay = longint'($signed(it.axis_y));
        az = longint'($signed(it.axis_z));
        d2 = dx * dx + dy * dy + dz * dz;
        a2 = ax * ax + ay * ay + az * az;
        dot = ax * dx + ay * dy + az * dz;
        adot = (dot < 0) ? -dot : dot;
        r2 = longint'(radius) * longint'(radius);
        dot_sq = 128'(adot) * 128'(adot);
        ad_sq = 128'(a2) * 128'(d2);
        in_sphere = (d2 <= r2);
        band = (d2 < BAND70_D2 && below_neg_cos(dot, dot_sq, ad_sq, COS70_NUM, COS70_DEN))
            || (d2 < BAND48_D2 && below_neg_cos(dot, dot_sq, ad_sq, COS48_NUM, COS48_DEN))
            || (d2 < BAND30_D2 && below_neg_cos(dot, dot_sq, ad_sq, COS30_NUM, COS30_DEN));
        outside_cone = (dot <= 0) || ((dot_sq * 128'd2) < ad_sq);
        res.accepted = in_sphere && !band && outside_cone;
        res.inside_sphere = in_sphere;
        res.backward_band = band;
        return res;
    endfunction

    // transfer monitor and result checker
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            expected_q.push_back(classify_point(i_item, radius_model));
        end
        if (i_rst_n && o_strobe) begin
            if (expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result acc=%0b in=%0b band=%0b at %0t",
                             o_result.accepted, o_result.inside_sphere,
                             o_result.backward_band, $realtime);
                end
            end else begin
                want = expected_q.pop_front();
                if (o_result.accepted !== want.accepted
                        || o_result.inside_sphere !== want.inside_sphere
                        || o_result.backward_band !== want.backward_band) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"mismatch at %0t: expected acc=%0b in=%0b band=%0b,",
                                  " got acc=%0b in=%0b band=%0b"},
                                 $realtime, want.accepted, want.inside_sphere,
                                 want.backward_band, o_result.accepted,
                                 o_result.inside_sphere, o_result.backward_band);
                    end
                end
            end
        end
        if (!i_rst_n) begin
            radius_model <= '0;
        end else if (i_cfg_we) begin
            radius_model <= i_cfg_data;
        end
    end

    function automatic int srand(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic scpc_pkg::t_item build_item(int ox, int oy, int oz,
                                                   int ax, int ay, int az,
                                                   int dx, int dy, int dz);
        scpc_pkg::t_item it;
        it.origin_x = 16'(ox);
        it.origin_y = 16'(oy);
        it.origin_z = 16'(oz);
        it.axis_x = 16'(ax);
        it.axis_y = 16'(ay);
        it.axis_z = 16'(az);
        it.point_x = 16'(ox + dx);
        it.point_y = 16'(oy + dy);
        it.point_z = 16'(oz + dz);
        return it;
    endfunction

    // mix of raw bit patterns, points near the sphere, backward points and cone edges
    function automatic scpc_pkg::t_item random_item(int reach);
        logic [159:0] bits;
        int           pick, ox, oy, oz, k, s, n, ux, uy, uz;
        pick = $urandom_range(0, 99);
        ox = srand(20000);
        oy = srand(20000);
        oz = srand(20000);
        if (pick < 20) begin
            bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
            return scpc_pkg::t_item'(bits[$bits(scpc_pkg::t_item)-1:0]);
        end else if (pick < 45) begin
            return build_item(ox, oy, oz, srand(32767), srand(32767), srand(32767),
                              srand(reach), srand(reach), srand(reach));
        end else if (pick < 80) begin
            k = $urandom_range(1, 1200);
            ux = srand(k);
            uy = srand(k);
            uz = srand(k);
            if (ux == 0 && uy == 0 && uz == 0) ux = k;
            s = $urandom_range(1, 20);
            n = $urandom_range(0, k / 6);
            return build_item(ox, oy, oz, ux * s, uy * s, uz * s,
                              -ux + srand(n), -uy + srand(n), -uz + srand(n));
        end else begin
            k = $urandom_range(1, 2000);
            s = $urandom_range(1, 30000);
            n = k / 20 + 1;
            return build_item(ox, oy, oz, s, 0, 0, k,
                              ($urandom_range(0, 1) ? k : -k) + srand(n), srand(n));
        end
    endfunction

    task automatic send_item(scpc_pkg::t_item it);
        start <= 1'b1;
        i_item <= it;
        @(negedge i_clk);
        while (busy) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_radius(int value);
        wait_for_results();
        i_cfg_we <= 1'b1;
        i_cfg_data <= scpc_pkg::RADIUS_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_radius();
        send_item(build_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(build_item(0, 0, 0, 1, 0, 0, 1, 0, 0));
    endtask

    task automatic test_field_extremes();
        write_radius(RADIUS_MAX);
        send_item(build_item(-32768, -32768, -32768, 32767, -32768, 32767,
                             65535, 65535, 65535));
        send_item(build_item(32767, 32767, 32767, -32768, -32768, -32768,
                             -65535, -65535, -65535));
        send_item(build_item(-32768, 32767, -32768, -32768, 32767, -32768, 0, 0, 0));
    endtask

    task automatic test_zero_length();
        send_item(build_item(0, 0, 0, 0, 0, 0, 100, 0, 0));
        send_item(build_item(5, 5, 5, 1, 2, 3, 0, 0, 0));
        send_item(build_item(-7, 9, 300, 0, 0, 0, -40, 2, 1));
    endtask

    task automatic test_backward_bands();
        send_item(build_item(0, 0, 0, 1, 0, 0, -100, 0, 0));
        send_item(build_item(0, 0, 0, 3, 0, 0, -1119, 0, 0));
        send_item(build_item(0, 0, 0, 3, 0, 0, -1120, 0, 0));
        send_item(build_item(10, 20, 30, 50, 0, 0, -100, 10, 0));
        send_item(build_item(10, 20, 30, 50, 0, 0, -600, 60, 0));
        send_item(build_item(10, 20, 30, 50, 0, 0, -900, 90, 0));
        send_item(build_item(-5, 0, 0, 7, 0, 0, -100, 15, 0));
        send_item(build_item(-5, 0, 0, 7, 0, 0, -600, 90, 0));
    endtask

    task automatic test_cone_boundary();
        send_item(build_item(0, 0, 0, 1, 0, 0, 100, 0, 0));
        send_item(build_item(0, 0, 0, 1, 0, 0, 100, 100, 0));
        send_item(build_item(0, 0, 0, 1, 0, 0, 100, 101, 0));
        send_item(build_item(0, 0, 0, 1, 0, 0, -100, -100, 0));
    endtask

    task automatic test_sphere_boundary();
        write_radius(100);
        send_item(build_item(1000, -1000, 0, 0, 1, 0, 100, 0, 0));
        send_item(build_item(1000, -1000, 0, 0, 1, 0, 101, 0, 0));
        send_item(build_item(0, 0, 0, 1, 0, 0, -101, 0, 0));
    endtask

    task automatic test_random_phases();
        int radii[5];
        int reach;
        logic quiet;
        radii = '{1120, RADIUS_MAX, 0, $urandom_range(1, RADIUS_MAX - 1), 768};
        foreach (radii[p]) begin
            write_radius(radii[p]);
            reach = (radii[p] < 32700) ? radii[p] + 64 : 32767;
            quiet = 1'b0;
            for (int i = 0; i < 260; i++) begin
                if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
                send_item(random_item(reach));
                if (!quiet && $urandom_range(0, 3) == 0) begin
                    pause_sender($urandom_range(1, 10));
                end
            end
        end
    endtask

    task automatic test_drain_pause();
        write_radius(1500);
        repeat (20) send_item(random_item(1600));
        wait_for_results();
        repeat (20) send_item(random_item(1600));
    endtask

    task automatic test_back_to_back();
        write_radius($urandom_range(480, 2000));
        repeat (200) send_item(random_item(2100));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_radius();
        test_field_extremes();
        test_zero_length();
        test_backward_bands();
        test_cone_boundary();
        test_sphere_boundary();
        test_random_phases();
        test_drain_pause();
        test_back_to_back();
        start <= 1'b0;
        for (int n = 0; n < 2000 && expected_q.size() != 0; n++) begin
            @(posedge i_clk);
        end
        repeat (scpc_pkg::LATENCY + 4) @(posedge i_clk);
        mismatch_count += expected_q.size();
        if (mismatch_count == 0) begin
            $display("sphere_cone_point_classifier test passed");
        end else begin
            $display("sphere_cone_point_classifier test failed");
        end
        $finish;
    end

endmodule
